FILE: src/dqks_pkg.sv
// ----------------------------------------------------------------------------
// dqks_pkg
// Shared types and codes for the double-ended queue with key search.
// ----------------------------------------------------------------------------
`default_nettype none

package dqks_pkg;

   // operation codes carried in the request mode field
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_SEARCH     = 3'd4;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_MISS  = 2'd3;

   // response field widths
   localparam int unsigned KEY_PORT_WIDTH   = 32;
   localparam int unsigned POS_PORT_WIDTH   = 4;
   localparam int unsigned COUNT_PORT_WIDTH = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_POP_WAIT,
      ST_SEARCH,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: src/dqks_ram.sv
// ----------------------------------------------------------------------------
// dqks_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dqks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/deque_with_key_search.sv
// ----------------------------------------------------------------------------
// deque_with_key_search
// Bounded double-ended queue of keys with a linear search over the entries.
// ----------------------------------------------------------------------------
// Keys live in a circular buffer in one RAM with a registered read port; a
// small sequencer drives it and one key comparator. One request is handled at
// a time. A search compares n entries, where n is the position of the first
// match plus one, or the whole entry count on a miss, as the RAM read port
// delivers one entry per cycle. A new request is taken once the previous one
// has been placed in the output register, even while that result still waits
// for the consumer; the following result then waits in the sequencer until
// that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_key_search #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic        [2:0]  req_mode,
   input  wire logic signed [31:0] req_key_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed      [31:0] rsp_key_out,
   output logic             [1:0]  rsp_status,
   output logic             [3:0]  rsp_match_position,
   output logic             [4:0]  rsp_entry_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   // control state
   dqks_pkg::state_type state_ff, state_in;
   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // item and scan payload
   logic [2:0]           item_mode_ff, item_mode_in;
   logic [KEY_WIDTH-1:0] item_key_ff, item_key_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [KEY_WIDTH-1:0] res_key_ff, res_key_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic [AW-1:0]        res_pos_ff, res_pos_in;
   logic signed [31:0]   rsp_key_ff, rsp_key_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [3:0]           rsp_pos_ff, rsp_pos_in;
   logic [4:0]           rsp_count_ff, rsp_count_in;

   // ram port
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [KEY_WIDTH-1:0] rd_data;

   // helpers
   logic [KEY_WIDTH+31:0] key_ext_wide;
   logic [KEY_WIDTH+31:0] res_key_wide;
   logic [AW+3:0]         res_pos_wide;
   logic [CW+4:0]         count_wide;
   logic [AW:0]           tail_sum;
   logic                  is_full;
   logic                  is_empty;
   logic                  is_last;
   logic                  key_hit;

   function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] x);
      logic [AW:0] y;
      y = (x >= (AW+1)'(DEPTH)) ? x - (AW+1)'(DEPTH) : x;
      return y[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] x);
      return (x == AW'(DEPTH - 1)) ? '0 : x + AW'(1);
   endfunction

   function automatic logic [AW-1:0] dec_idx(input logic [AW-1:0] x);
      return (x == '0) ? AW'(DEPTH - 1) : x - AW'(1);
   endfunction

   dqks_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item_key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign key_ext_wide = {{KEY_WIDTH{1'b0}}, req_key_in};
   assign res_key_wide = {32'b0, res_key_ff};
   assign res_pos_wide = {4'b0, res_pos_ff};
   assign count_wide   = {5'b0, count_ff};
   assign tail_sum     = (AW+1)'(front_ff) + (AW+1)'(count_ff);
   assign is_full      = (count_ff == CW'(DEPTH));
   assign is_empty     = (count_ff == '0);
   assign is_last      = ((CW'(pos_ff) + CW'(1)) == count_ff);
   assign key_hit      = (rd_data == item_key_ff);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      item_mode_in  = item_mode_ff;
      item_key_in   = item_key_ff;
      pos_in        = pos_ff;
      addr_in       = addr_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      req_stall     = 1'b1;

      case (state_ff)
         dqks_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               item_mode_in = req_mode;
               item_key_in  = key_ext_wide[KEY_WIDTH-1:0];
               state_in     = dqks_pkg::ST_DISPATCH;
            end
         end
         dqks_pkg::ST_DISPATCH: begin
            res_key_in    = '0;
            res_status_in = dqks_pkg::STATUS_OK;
            res_pos_in    = '0;
            state_in      = dqks_pkg::ST_FINISH;
            case (item_mode_ff)
               dqks_pkg::MODE_PUSH_FRONT: begin
                  if (is_full) begin
                     res_status_in = dqks_pkg::STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = dec_idx(front_ff);
                     front_in = dec_idx(front_ff);
                     count_in = count_ff + CW'(1);
                  end
               end
               dqks_pkg::MODE_PUSH_BACK: begin
                  if (is_full) begin
                     res_status_in = dqks_pkg::STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = wrap_idx(tail_sum);
                     count_in = count_ff + CW'(1);
                  end
               end
               dqks_pkg::MODE_POP_FRONT: begin
                  if (is_empty) begin
                     res_status_in = dqks_pkg::STATUS_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = front_ff;
                     front_in = inc_idx(front_ff);
                     count_in = count_ff - CW'(1);
                     state_in = dqks_pkg::ST_POP_WAIT;
                  end
               end
               dqks_pkg::MODE_POP_BACK: begin
                  if (is_empty) begin
                     res_status_in = dqks_pkg::STATUS_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = wrap_idx(tail_sum - (AW+1)'(1));
                     count_in = count_ff - CW'(1);
                     state_in = dqks_pkg::ST_POP_WAIT;
                  end
               end
               dqks_pkg::MODE_SEARCH: begin
                  if (is_empty) begin
                     res_status_in = dqks_pkg::STATUS_MISS;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = front_ff;
                     addr_in  = front_ff;
                     pos_in   = '0;
                     state_in = dqks_pkg::ST_SEARCH;
                  end
               end
               default: begin
               end
            endcase
         end
         dqks_pkg::ST_POP_WAIT: begin
            res_key_in = rd_data;
            state_in   = dqks_pkg::ST_FINISH;
         end
         dqks_pkg::ST_SEARCH: begin
            // rd_data holds the entry at pos_ff; unless it matches or is the last, the next one is fetched meanwhile
            if (key_hit) begin
               res_key_in = item_key_ff;
               res_pos_in = pos_ff;
               state_in   = dqks_pkg::ST_FINISH;
            end else if (is_last) begin
               res_status_in = dqks_pkg::STATUS_MISS;
               state_in      = dqks_pkg::ST_FINISH;
            end else begin
               rd_en   = 1'b1;
               rd_addr = inc_idx(addr_ff);
               addr_in = inc_idx(addr_ff);
               pos_in  = pos_ff + AW'(1);
            end
         end
         dqks_pkg::ST_FINISH: begin
            // output register must be empty or draining this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_key_in    = signed'(res_key_wide[31:0]);
               rsp_status_in = res_status_ff;
               rsp_pos_in    = res_pos_wide[3:0];
               rsp_count_in  = count_wide[4:0];
               state_in      = dqks_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dqks_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dqks_pkg::ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_mode_ff  <= item_mode_in;
      item_key_ff   <= item_key_in;
      pos_ff        <= pos_in;
      addr_ff       <= addr_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_key_out        = rsp_key_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_entry_count    = rsp_count_ff;

   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   ap_search_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == dqks_pkg::ST_SEARCH |-> count_ff != '0)
      else $error("search scan running on an empty queue");

   ap_full_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dqks_pkg::ST_FINISH && res_status_ff == dqks_pkg::STATUS_FULL)
         |-> count_ff == CW'(DEPTH))
      else $error("full status with free entries");

   ap_empty_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dqks_pkg::ST_FINISH && res_status_ff == dqks_pkg::STATUS_EMPTY)
         |-> count_ff == '0)
      else $error("empty status with entries held");

   ap_count_update: assert property (@(posedge clock) disable iff (reset)
      state_ff != dqks_pkg::ST_DISPATCH |=> $stable(count_ff))
      else $error("entry count changed outside dispatch");

endmodule

`default_nettype wire

FILE: dv/deque_with_key_search_tb.sv
// ----------------------------------------------------------------------------
// deque_with_key_search_tb
// Self-checking bench for the key deque: a short directed table covering the
// empty, full and miss cases, then random push/pop/search traffic whose
// results are checked against a mirror of the queue kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module deque_with_key_search_tb;

   localparam int DEPTH          = 16;
   localparam int RANDOM_ITEMS   = 1250;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 40;
   localparam int CYCLE_LIMIT    = 400000;

   // mode codes the block takes but does nothing with
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [31:0] key;
      logic [1:0]  status;
      logic [3:0]  pos;
      logic [4:0]  count;
   } rsp_type;

   typedef struct {
      logic [2:0]  mode;
      logic [31:0] key;
      bit          typed;
      rsp_type     rsp;
   } dir_row_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_valid  = 1'b0;
   logic               req_stall;
   logic        [2:0]  req_mode   = dqks_pkg::MODE_PUSH_BACK;
   logic signed [31:0] req_key_in = '0;
   logic               rsp_valid;
   logic               rsp_stall  = 1'b1;
   logic signed [31:0] rsp_key_out;
   logic        [1:0]  rsp_status;
   logic        [3:0]  rsp_match_position;
   logic        [4:0]  rsp_entry_count;

   // mirror of the queue contents, updated at each request transfer
   logic [31:0] mirror_keys [DEPTH];
   logic [3:0]  mirror_front = '0;
   logic [4:0]  mirror_count = '0;

   rsp_type     deque_rsp_q [$];
   dir_row_type dir_rows [$];
   rsp_type     head_rsp;
   int          fail_count   = 0;
   int          burst_left   = 0;
   int          holdoff_seq  = 0;
   int          holdoff_seen = 0;
   int          holdoff_left = 0;
   int          cycle_count  = 0;
   logic [5:0]  rx_cycle     = '0;
   stall_style_type stall_style = STALL_NONE;

   deque_with_key_search DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_key_in         (req_key_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_key_out        (rsp_key_out),
      .rsp_status         (rsp_status),
      .rsp_match_position (rsp_match_position),
      .rsp_entry_count    (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type mk_rsp(input logic [31:0] key, input logic [1:0] status,
                                      input logic [3:0] pos, input logic [4:0] count);
      rsp_type r;
      r.key    = key;
      r.status = status;
      r.pos    = pos;
      r.count  = count;
      return r;
   endfunction

   // applies one operation to the mirror and returns the result it yields
   function automatic rsp_type deque_op_result(input logic [2:0] op,
                                               input logic [31:0] key);
      rsp_type    r;
      logic [3:0] slot;
      r = '0;
      case (op)
         dqks_pkg::MODE_PUSH_FRONT: begin
            if (mirror_count == DEPTH) begin
               r.status = dqks_pkg::STATUS_FULL;
            end else begin
               mirror_front = mirror_front - 4'd1;
               mirror_keys[mirror_front] = key;
               mirror_count = mirror_count + 5'd1;
            end
         end
         dqks_pkg::MODE_PUSH_BACK: begin
            if (mirror_count == DEPTH) begin
               r.status = dqks_pkg::STATUS_FULL;
            end else begin
               slot = mirror_front + mirror_count[3:0];
               mirror_keys[slot] = key;
               mirror_count = mirror_count + 5'd1;
            end
         end
         dqks_pkg::MODE_POP_FRONT: begin
            if (mirror_count == 0) begin
               r.status = dqks_pkg::STATUS_EMPTY;
            end else begin
               r.key = mirror_keys[mirror_front];
               mirror_front = mirror_front + 4'd1;
               mirror_count = mirror_count - 5'd1;
            end
         end
         dqks_pkg::MODE_POP_BACK: begin
            if (mirror_count == 0) begin
               r.status = dqks_pkg::STATUS_EMPTY;
            end else begin
               slot = mirror_front + mirror_count[3:0] - 4'd1;
               r.key = mirror_keys[slot];
               mirror_count = mirror_count - 5'd1;
            end
         end
         dqks_pkg::MODE_SEARCH: begin
            r.status = dqks_pkg::STATUS_MISS;
            for (int i = 0; i < mirror_count; i++) begin
               slot = mirror_front + i[3:0];
               if (mirror_keys[slot] == key) begin
                  r.status = dqks_pkg::STATUS_OK;
                  r.pos    = i[3:0];
                  r.key    = key;
                  break;
               end
            end
         end
         default: ;
      endcase
      r.count = mirror_count;
      return r;
   endfunction

   // half of the searches on a non-empty queue pick a stored key; a small pool of values makes duplicates likely
   function automatic logic [31:0] pick_key(input bit for_search);
      int unsigned sel;
      logic [3:0]  slot;
      sel = $urandom_range(0, 9);
      if (for_search && mirror_count != 0 && sel < 5) begin
         slot = mirror_front + 4'($urandom_range(0, mirror_count - 1));
         return mirror_keys[slot];
      end
      if (sel < 7) begin
         case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom_range(1, 4);
         endcase
      end
      return $urandom;
   endfunction

   task automatic add_row(input logic [2:0] op, input logic [31:0] key, input bit typed,
                          input rsp_type rsp);
      dir_row_type row;
      row.mode  = op;
      row.key   = key;
      row.typed = typed;
      row.rsp   = rsp;
      dir_rows.push_back(row);
   endtask

   // offers one request and waits for its transfer
   task automatic transfer_req(input logic [2:0] op, input logic [31:0] key, input bit typed,
                               input rsp_type typed_rsp);
      rsp_type r;
      req_valid  <= 1'b1;
      req_mode   <= op;
      req_key_in <= key;
      do @(posedge clock); while (!(req_valid && !req_stall));
      r = deque_op_result(op, key);
      deque_rsp_q.push_back(typed ? typed_rsp : r);
   endtask

   task automatic sender_idle();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (deque_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         fail_count++;
      end
   endtask

   // stimulus
   initial begin
      logic [2:0]  op;
      logic [31:0] key;
      int          push_pct;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_row(dqks_pkg::MODE_POP_FRONT, 32'hDEAD_BEEF, 1'b1,
              mk_rsp('0, dqks_pkg::STATUS_EMPTY, '0, 5'd0));
      add_row(dqks_pkg::MODE_POP_BACK, 32'h0000_0000, 1'b1,
              mk_rsp('0, dqks_pkg::STATUS_EMPTY, '0, 5'd0));
      add_row(dqks_pkg::MODE_SEARCH, 32'h0000_0000, 1'b1,
              mk_rsp('0, dqks_pkg::STATUS_MISS, '0, 5'd0));
      add_row(MODE_SPARE_FIRST, 32'hFFFF_FFFF, 1'b1,
              mk_rsp('0, dqks_pkg::STATUS_OK, '0, 5'd0));
      add_row(dqks_pkg::MODE_PUSH_BACK, 32'h7FFF_FFFF, 1'b1,
              mk_rsp('0, dqks_pkg::STATUS_OK, '0, 5'd1));
      add_row(dqks_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 1'b1,
              mk_rsp('0, dqks_pkg::STATUS_OK, '0, 5'd2));
      add_row(dqks_pkg::MODE_SEARCH, 32'h7FFF_FFFF, 1'b1,
              mk_rsp(32'h7FFF_FFFF, dqks_pkg::STATUS_OK, 4'd1, 5'd2));
      add_row(dqks_pkg::MODE_SEARCH, 32'h8000_0000, 1'b1,
              mk_rsp(32'h8000_0000, dqks_pkg::STATUS_OK, 4'd0, 5'd2));
      // fill to the top from both ends
      for (int i = 0; i < DEPTH - 2; i++) begin
         add_row(i[0] ? dqks_pkg::MODE_PUSH_FRONT : dqks_pkg::MODE_PUSH_BACK,
                 (i == DEPTH - 3) ? 32'hFFFF_FFFF : 32'h0101_0101 * i, 1'b0, '0);
      end
      add_row(dqks_pkg::MODE_PUSH_BACK, 32'h5555_5555, 1'b1,
              mk_rsp('0, dqks_pkg::STATUS_FULL, '0, 5'd16));
      add_row(dqks_pkg::MODE_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1,
              mk_rsp('0, dqks_pkg::STATUS_FULL, '0, 5'd16));
      add_row(dqks_pkg::MODE_SEARCH, 32'h1234_5678, 1'b1,
              mk_rsp('0, dqks_pkg::STATUS_MISS, '0, 5'd16));

      foreach (dir_rows[j]) begin
         transfer_req(dir_rows[j].mode, dir_rows[j].key, dir_rows[j].typed, dir_rows[j].rsp);
         sender_idle();
      end
      drain_results();

      push_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // swing between filling and draining so both full and empty are reached
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 15;
               1:       push_pct = 50;
               default: push_pct = 85;
            endcase
         end
         if (n == 300 || n == 900) holdoff_seq <= holdoff_seq + 1;
         if (n == 600 || n == 1100) drain_results();
         if ($urandom_range(0, 99) < 4) begin
            op = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
         end else if ($urandom_range(0, 99) < 30) begin
            op = dqks_pkg::MODE_SEARCH;
         end else if ($urandom_range(0, 99) < push_pct) begin
            op = $urandom_range(0, 1) ? dqks_pkg::MODE_PUSH_FRONT : dqks_pkg::MODE_PUSH_BACK;
         end else begin
            op = $urandom_range(0, 1) ? dqks_pkg::MODE_POP_FRONT : dqks_pkg::MODE_POP_BACK;
         end
         key = pick_key(op == dqks_pkg::MODE_SEARCH);
         transfer_req(op, key, 1'b0, '0);
         sender_idle();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // receiver stall pattern, with long hold-offs on request from the stimulus
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 6'd1;
      if (holdoff_left != 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_seen != holdoff_seq) begin
         holdoff_seen <= holdoff_seq;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         if (rx_cycle == 0) stall_style <= stall_style_type'($urandom_range(0, 3));
         case (stall_style)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= rx_cycle[2];
         endcase
      end
   end

   // result transfers against the oldest outstanding entry
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (deque_rsp_q.size() == 0) begin
            $display("%0t: result transfer with nothing outstanding, key %h status %0d",
                     $time, rsp_key_out, rsp_status);
            fail_count++;
         end else begin
            head_rsp = deque_rsp_q.pop_front();
            check_field("key_out", head_rsp.key, rsp_key_out);
            check_field("status", 32'(head_rsp.status), 32'(rsp_status));
            check_field("match_position", 32'(head_rsp.pos), 32'(rsp_match_position));
            check_field("entry_count", 32'(head_rsp.count), 32'(rsp_entry_count));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: deque_with_key_search.f
src/dqks_pkg.sv
src/dqks_ram.sv
src/deque_with_key_search.sv
dv/deque_with_key_search_tb.sv
